// ===== design/obdr_pkg.sv =====
// obdr_pkg: shared types and constants for the obd transport reassembly block
// no dependencies
`default_nettype none
package obdr_pkg;
    localparam int NumSlots   = 8;
    localparam int MaxPayload = 64;
    localparam int SlotW      = $clog2(NumSlots);
    localparam int PosW       = $clog2(MaxPayload);
    localparam int LenW       = $clog2(MaxPayload + 1);
    localparam int MemW       = SlotW + PosW;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FLOW  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [3:0] FT_SINGLE = 4'd0;
    localparam logic [3:0] FT_FIRST  = 4'd1;
    localparam logic [3:0] FT_CONSEC = 4'd2;

    localparam logic [0:0] CFG_FLOW_OFFSET = 1'd0;
    localparam logic [0:0] CFG_FLOW_STATUS = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture input item and decode
        logic apply;    // update slot tables and store bytes
        logic emit_rd;  // issue memory read for next byte
        logic out_load; // load output register
        logic out_clr;  // output taken
    } obdr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       drop;      // item causes nothing
        logic       flow;      // first frame: one flow result
        logic       single;    // single frame: bytes from the frame
        logic       complete;  // consecutive frame completes a message
        logic       out_valid;
        logic       out_ready;
        logic       more;      // more bytes to emit
        logic       wr_busy;   // payload bytes still being written
    } obdr_sts_t;
endpackage
`default_nettype wire

// ===== design/obdr_ctrl.sv =====
// obdr_ctrl: sequencer for frame handling and result emission
// depends on obdr_pkg
`default_nettype none
module obdr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire obdr_pkg::obdr_sts_t sts,
    output obdr_pkg::obdr_cmd_t    cmd
);
    import obdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_APPLY, ST_READ, ST_EMIT, ST_DRAIN
    } state_t;

    state_t state_reg;

    always_comb begin
        cmd = '0;
        // a new frame waits until the previous frame's bytes are stored
        s_ready = (state_reg == ST_IDLE) && !sts.wr_busy;
        cmd.load = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE:   ;
            ST_DECODE: cmd.apply = 1'b1;
            ST_APPLY:  ;
            ST_READ:   cmd.emit_rd = 1'b1;
            ST_EMIT: begin
                if (!sts.out_valid || sts.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.emit_rd = sts.more;
                end
            end
            ST_DRAIN:  ;
            default:   ;
        endcase
        cmd.out_clr = sts.out_valid && sts.out_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE:   if (cmd.load) state_reg <= ST_DECODE;
                ST_DECODE: state_reg <= ST_APPLY;
                ST_APPLY: begin
                    if (sts.drop) state_reg <= ST_IDLE;
                    else if (sts.complete) state_reg <= ST_READ;
                    else state_reg <= ST_EMIT;
                end
                ST_READ:   state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (!sts.out_valid || sts.out_ready) begin
                        if (!sts.more) state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_DECODE) else $error("load not decoded");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> state_reg == ST_EMIT) else $error("read lost");
endmodule
`default_nettype wire

// ===== design/obdr_dp.sv =====
// obdr_dp: slot tables, payload memory and output register
// depends on obdr_pkg
`default_nettype none
module obdr_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire obdr_pkg::obdr_cmd_t cmd,
    output obdr_pkg::obdr_sts_t      sts,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [10:0]         cfg_data,
    input  wire logic [10:0]         s_frame_id,
    input  wire logic [7:0]          s_byte0,
    input  wire logic [7:0]          s_byte1,
    input  wire logic [7:0]          s_byte2,
    input  wire logic [7:0]          s_byte3,
    input  wire logic [7:0]          s_byte4,
    input  wire logic [7:0]          s_byte5,
    input  wire logic [7:0]          s_byte6,
    input  wire logic [7:0]          s_byte7,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_result_kind,
    output logic [10:0]              m_target_id,
    output logic [5:0]               m_service,
    output logic [7:0]               m_param_id,
    output logic [7:0]               m_data_byte,
    output logic [5:0]               m_byte_index,
    output logic                     m_last
);
    import obdr_pkg::*;

    logic [10:0] flow_off_reg;
    logic [7:0]  flow_stat_reg;

    logic [10:0] id_reg;
    logic [7:0]  b_reg [8];

    logic              sv_reg [NumSlots];
    logic [10:0]       sid_reg [NumSlots];
    logic [3:0]        sseq_reg [NumSlots];
    logic [LenW-1:0]   stot_reg [NumSlots];
    logic [LenW-1:0]   sfil_reg [NumSlots];
    logic [4:0]        ssvc_reg [NumSlots];
    logic [7:0]        spar_reg [NumSlots];

    logic [7:0] mem [NumSlots*MaxPayload];
    logic [7:0] rd_data_reg;

    // decode results, registered in the decode cycle
    logic            drop_reg, flow_reg, single_reg, complete_reg;
    logic [SlotW-1:0] slot_reg;

    // emission counters
    logic [LenW-1:0] cnt_reg;
    logic [LenW-1:0] total_reg;
    logic [5:0]      esvc_reg;
    logic [7:0]      epar_reg;

    // combinational decode
    logic [3:0]  ftype;
    logic [11:0] raw;
    logic [11:0] ff_len;
    logic        hit;
    logic [SlotW-1:0] hit_idx, free_idx;
    logic        free_ok;
    logic [2:0]  sf_len;
    logic [LenW-1:0] rem_full, rem7;

    always_comb begin
        ftype = b_reg[0][7:4];
        raw = {b_reg[0][3:0], b_reg[1]};
        ff_len = raw - 12'd2;
        sf_len = b_reg[0][2:0];
        hit = 1'b0;
        hit_idx = '0;
        free_ok = 1'b0;
        free_idx = '0;
        for (int s = NumSlots - 1; s >= 0; s--) begin
            if (sv_reg[s] && sid_reg[s] == id_reg) begin
                hit = 1'b1;
                hit_idx = SlotW'(s);
            end
            if (!sv_reg[s]) begin
                free_ok = 1'b1;
                free_idx = SlotW'(s);
            end
        end
        rem_full = stot_reg[hit_idx] - sfil_reg[hit_idx];
        rem7 = (rem_full > LenW'(7)) ? LenW'(7) : rem_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_off_reg <= 11'd8;
            flow_stat_reg <= 8'h30;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FLOW_OFFSET: flow_off_reg <= cfg_data;
                default:         flow_stat_reg <= cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg <= s_frame_id;
            b_reg[0] <= s_byte0; b_reg[1] <= s_byte1;
            b_reg[2] <= s_byte2; b_reg[3] <= s_byte3;
            b_reg[4] <= s_byte4; b_reg[5] <= s_byte5;
            b_reg[6] <= s_byte6; b_reg[7] <= s_byte7;
        end
    end

    // decode stage: classify item
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            slot_reg <= hit ? hit_idx : free_idx;
            flow_reg <= 1'b0;
            single_reg <= 1'b0;
            complete_reg <= 1'b0;
            drop_reg <= 1'b1;
            if (id_reg[10:8] == 3'b111) begin
                case (ftype)
                    FT_SINGLE: if (b_reg[1][6]) begin
                        single_reg <= 1'b1;
                        drop_reg <= 1'b0;
                    end
                    FT_FIRST: begin
                        flow_reg <= 1'b1;
                        drop_reg <= 1'b0;
                    end
                    FT_CONSEC: if (hit && sseq_reg[hit_idx] == b_reg[0][3:0]) begin
                        complete_reg <= (sfil_reg[hit_idx] + rem7) == stot_reg[hit_idx];
                        drop_reg <= !((sfil_reg[hit_idx] + rem7) == stot_reg[hit_idx]);
                    end
                    default: ;
                endcase
            end
        end
    end

    // one-cycle pulse: decode done, load emission counters; payload byte-write state
    logic apply_d_reg;
    logic [2:0] wcnt_reg;
    logic       wr_act_reg;
    logic [LenW-1:0] wbase_reg;
    logic [2:0] wlen_reg;
    logic [3:0] woff_reg;
    logic [SlotW-1:0] wslot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apply_d_reg <= 1'b0;
            for (int s = 0; s < NumSlots; s++) begin
                sv_reg[s] <= 1'b0;
                sid_reg[s] <= '0; sseq_reg[s] <= '0; stot_reg[s] <= '0;
                sfil_reg[s] <= '0; ssvc_reg[s] <= '0; spar_reg[s] <= '0;
            end
        end else begin
            apply_d_reg <= cmd.apply;
            if (cmd.apply && id_reg[10:8] == 3'b111) begin
                if (ftype == FT_FIRST && !(raw < 12'd6 || ff_len > 12'(MaxPayload))
                    && (hit || free_ok)) begin
                    sv_reg[hit ? hit_idx : free_idx] <= 1'b1;
                    sid_reg[hit ? hit_idx : free_idx] <= id_reg;
                    sseq_reg[hit ? hit_idx : free_idx] <= 4'd1;
                    stot_reg[hit ? hit_idx : free_idx] <= ff_len[LenW-1:0];
                    sfil_reg[hit ? hit_idx : free_idx] <= LenW'(4);
                    ssvc_reg[hit ? hit_idx : free_idx] <= b_reg[2][4:0];
                    spar_reg[hit ? hit_idx : free_idx] <= b_reg[3];
                end else if (ftype == FT_CONSEC && hit
                             && sseq_reg[hit_idx] == b_reg[0][3:0]) begin
                    sseq_reg[hit_idx] <= sseq_reg[hit_idx] + 4'd1;
                    sfil_reg[hit_idx] <= sfil_reg[hit_idx] + rem7;
                    if ((sfil_reg[hit_idx] + rem7) == stot_reg[hit_idx])
                        sv_reg[hit_idx] <= 1'b0;
                end
            end
        end
    end

    // payload byte writes: one byte per cycle, started by the decode cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_act_reg <= 1'b0;
            wcnt_reg <= '0;
        end else if (cmd.apply && id_reg[10:8] == 3'b111) begin
            wcnt_reg <= '0;
            wr_act_reg <= 1'b0;
            if (ftype == FT_FIRST && !(raw < 12'd6 || ff_len > 12'(MaxPayload))
                && (hit || free_ok)) begin
                wr_act_reg <= 1'b1;
                wslot_reg <= hit ? hit_idx : free_idx;
                wbase_reg <= '0;
                wlen_reg <= 3'd4;
                woff_reg <= 4'd4;
            end else if (ftype == FT_CONSEC && hit
                         && sseq_reg[hit_idx] == b_reg[0][3:0] && rem7 != '0) begin
                wr_act_reg <= 1'b1;
                wslot_reg <= hit_idx;
                wbase_reg <= sfil_reg[hit_idx];
                wlen_reg <= rem7[2:0];
                woff_reg <= 4'd1;
            end
        end else if (wr_act_reg) begin
            wcnt_reg <= wcnt_reg + 3'd1;
            if (wcnt_reg + 3'd1 == wlen_reg) wr_act_reg <= 1'b0;
        end
    end

    logic [3:0]  wb_sel;
    logic [LenW-1:0] wpos;
    always_comb begin
        wb_sel = woff_reg + {1'b0, wcnt_reg};
        wpos = wbase_reg + LenW'(wcnt_reg);
    end

    logic [MemW-1:0] rd_addr;
    always_comb rd_addr = {slot_reg, cnt_reg[PosW-1:0]};

    always_ff @(posedge aclk) begin
        if (wr_act_reg)
            mem[{wslot_reg, wpos[PosW-1:0]}] <= b_reg[wb_sel[2:0]];
        if (cmd.emit_rd)
            rd_data_reg <= mem[rd_addr];
    end

    // emission bookkeeping
    logic [LenW-1:0] sf_cnt;
    always_comb sf_cnt = (sf_len <= 3'd2) ? LenW'(1) : LenW'(sf_len - 3'd2);

    logic [LenW-1:0] ocnt_reg;
    always_ff @(posedge aclk) begin
        if (apply_d_reg) begin
            cnt_reg <= '0;
            ocnt_reg <= '0;
            if (single_reg) begin
                total_reg <= sf_cnt;
                esvc_reg <= b_reg[1][5:0];
                epar_reg <= b_reg[2];
            end else if (complete_reg) begin
                total_reg <= stot_reg[slot_reg];
                esvc_reg <= {1'b0, ssvc_reg[slot_reg]};
                epar_reg <= spar_reg[slot_reg];
            end else begin
                total_reg <= LenW'(1);
            end
        end else begin
            if (cmd.emit_rd) cnt_reg <= cnt_reg + LenW'(1);
            if (cmd.out_load) ocnt_reg <= ocnt_reg + LenW'(1);
        end
    end

    logic [7:0] sf_byte;
    always_comb sf_byte = (ocnt_reg < LenW'(5)) ? b_reg[3'd3 + ocnt_reg[2:0]] : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (cmd.out_clr) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_last <= (ocnt_reg + LenW'(1)) == total_reg;
            m_byte_index <= ocnt_reg[5:0];
            m_target_id <= id_reg;
            m_service <= esvc_reg;
            m_param_id <= epar_reg;
            m_result_kind <= KIND_BYTE;
            if (flow_reg) begin
                m_result_kind <= KIND_FLOW;
                m_target_id <= id_reg - flow_off_reg;
                m_service <= '0;
                m_param_id <= '0;
                m_data_byte <= flow_stat_reg;
                m_byte_index <= '0;
            end else if (single_reg) begin
                if (sf_len <= 3'd2) begin
                    m_result_kind <= KIND_EMPTY;
                    m_data_byte <= '0;
                end else begin
                    m_data_byte <= sf_byte;
                end
            end else begin
                m_data_byte <= rd_data_reg;
            end
        end
    end

    always_comb begin
        sts.drop = drop_reg;
        sts.flow = flow_reg;
        sts.single = single_reg;
        sts.complete = complete_reg;
        sts.out_valid = m_valid;
        sts.out_ready = m_ready;
        sts.more = (ocnt_reg + LenW'(1)) != total_reg;
        sts.wr_busy = wr_act_reg;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(flow_reg && single_reg)) else $error("kind clash");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (ocnt_reg < total_reg)) else $error("emit overrun");
endmodule
`default_nettype wire

// ===== design/obd_transport_reassembly_top.sv =====
// obd_transport_reassembly_top: receive reassembly of segmented diagnostic frames
// depends on obdr_pkg, obdr_ctrl, obdr_dp
//
//  channel | ports                        | direction
//  s_      | s_valid/s_ready, frame fields| in, one can frame per item
//  m_      | m_valid/m_ready, result      | out, one result per item
//  cfg     | cfg_we, cfg_index, cfg_data  | in, register writes
//
// one frame at a time: accept, decode and slot update come first, in that order;
// a finished message adds one payload memory read, then one result per cycle
// while m_ready is high; payload bytes are stored one per cycle, so a first frame
// and a consecutive frame that does not finish a message hold s_ready low at least
// until their bytes are stored
// reset clears slot valid bits and the sequencer; payload memory is not cleared
// stalls on m_ready hold the sequencer; the next frame waits until idle
`default_nettype none
module obd_transport_reassembly_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [10:0] s_frame_id,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,
    input  wire logic [7:0]  s_byte4,
    input  wire logic [7:0]  s_byte5,
    input  wire logic [7:0]  s_byte6,
    input  wire logic [7:0]  s_byte7,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [10:0]      m_target_id,
    output logic [5:0]       m_service,
    output logic [7:0]       m_param_id,
    output logic [7:0]       m_data_byte,
    output logic [5:0]       m_byte_index,
    output logic             m_last
);
    import obdr_pkg::*;

    obdr_cmd_t cmd;
    obdr_sts_t sts;

    obdr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    obdr_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_frame_id(s_frame_id), .s_byte0(s_byte0), .s_byte1(s_byte1),
        .s_byte2(s_byte2), .s_byte3(s_byte3), .s_byte4(s_byte4),
        .s_byte5(s_byte5), .s_byte6(s_byte6), .s_byte7(s_byte7),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_target_id(m_target_id), .m_service(m_service),
        .m_param_id(m_param_id), .m_data_byte(m_data_byte),
        .m_byte_index(m_byte_index), .m_last(m_last)
    );
endmodule
`default_nettype wire
